FILE: rtl/lmdb_pkg.sv
// ----------------------------------------------------------------------------
// lmdb_pkg: shared types and constants for the latest-message double buffer
// Operation codes, status codes and the bit layout of the stream beats.
// ----------------------------------------------------------------------------
package lmdb_pkg;

   // Field widths fixed by the stream format.
   localparam int OPCODE_W      = 3;
   localparam int ID_W          = 32;
   localparam int PLEN_W        = 16;
   localparam int BYTE_W        = 8;
   localparam int OFFSET_W      = 12;
   localparam int STATUS_W      = 3;
   localparam int LENGTH_W      = 13;

   // Request tdata layout, lowest bit first.
   localparam int REQ_ID_LSB    = 0;
   localparam int REQ_PLEN_LSB  = REQ_ID_LSB + ID_W;
   localparam int REQ_BYTE_LSB  = REQ_PLEN_LSB + PLEN_W;
   localparam int REQ_OFS_LSB   = REQ_BYTE_LSB + BYTE_W;
   localparam int REQ_REL_BIT   = REQ_OFS_LSB + OFFSET_W;
   localparam int REQ_TDATA_W   = 72;

   // Response tdata layout, lowest bit first.
   localparam int RSP_STAT_LSB  = 0;
   localparam int RSP_IDX_BIT   = RSP_STAT_LSB + STATUS_W;
   localparam int RSP_LEN_LSB   = RSP_IDX_BIT + 1;
   localparam int RSP_DATA_LSB  = RSP_LEN_LSB + LENGTH_W;
   localparam int RSP_USED_W    = RSP_DATA_LSB + BYTE_W;
   localparam int RSP_TDATA_W   = 32;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Operation codes.
   localparam opcode_type OP_START   = 3'd0;
   localparam opcode_type OP_BYTE    = 3'd1;
   localparam opcode_type OP_ACQUIRE = 3'd2;
   localparam opcode_type OP_READ    = 3'd3;
   localparam opcode_type OP_RELEASE = 3'd4;

   // Status codes.
   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_IGNORED  = 3'd1;
   localparam status_type ST_NO_DATA  = 3'd2;
   localparam status_type ST_HELD     = 3'd3;
   localparam status_type ST_NOT_HELD = 3'd4;
   localparam status_type ST_WRONG    = 3'd5;
   localparam status_type ST_BUSY     = 3'd6;
   localparam status_type ST_RANGE    = 3'd7;

   localparam logic [LENGTH_W-1:0] MAX_LENGTH_RESET = 13'd4096;

endpackage

FILE: rtl/lmdb_ram.sv
// ----------------------------------------------------------------------------
// lmdb_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module lmdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/latest_message_double_buffer.sv
// ----------------------------------------------------------------------------
// latest_message_double_buffer: two-buffer store for the newest message
// Takes newer messages into the buffer the consumer does not hold and lets
// the consumer acquire, read and release a committed buffer.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  req_    | in        | tuser: opcode; tdata: id, length, byte, offset, buffer
//  rsp_    | out       | tdata: status, buffer index, length, read byte
//  csr_    | in        | csr_data: max_length, written whenever presented
//
//  One request beat is taken per cycle while req_tready is high; each gives
//  one response beat, registered in stage one and then in the response register.
//  The latency comes from the registered read port of the byte store.
//  Reset clears all control state at once; the byte store is not cleared.
//  A stall on rsp_ backs up into req_tready after the two stages fill.
// ----------------------------------------------------------------------------
module latest_message_double_buffer #(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // tuser: opcode[2:0]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lmdb_pkg::OPCODE_W-1:0]        req_tuser,
   // tdata: message_id[31:0], payload_length[47:32], data_byte[55:48],
   //        read_offset[67:56], release_buffer[68], zero fill[71:69]
   input  logic [lmdb_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // tdata: status[2:0], buffer_index[3], length[16:4], read_data[24:17],
   //        zero fill[31:25]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lmdb_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lmdb_pkg::LENGTH_W-1:0]        csr_data
);

   localparam int AW    = $clog2(BUFFER_BYTES);
   localparam int CW    = $clog2(BUFFER_BYTES + 1);
   localparam int CMP_W = (CW > lmdb_pkg::PLEN_W) ? CW : lmdb_pkg::PLEN_W;
   localparam int DEPTH = 2 * (2 ** AW);
   localparam logic [CMP_W-1:0] BUF_LIMIT = CMP_W'(BUFFER_BYTES);

   // Request fields.
   lmdb_pkg::opcode_type            opcode;
   logic [lmdb_pkg::ID_W-1:0]       message_id;
   logic [lmdb_pkg::PLEN_W-1:0]     payload_length;
   logic [lmdb_pkg::BYTE_W-1:0]     data_byte;
   logic [lmdb_pkg::OFFSET_W-1:0]   read_offset;
   logic                            release_buffer;

   assign opcode         = req_tuser;
   assign message_id     = req_tdata[lmdb_pkg::REQ_ID_LSB +: lmdb_pkg::ID_W];
   assign payload_length = req_tdata[lmdb_pkg::REQ_PLEN_LSB +: lmdb_pkg::PLEN_W];
   assign data_byte      = req_tdata[lmdb_pkg::REQ_BYTE_LSB +: lmdb_pkg::BYTE_W];
   assign read_offset    = req_tdata[lmdb_pkg::REQ_OFS_LSB +: lmdb_pkg::OFFSET_W];
   assign release_buffer = req_tdata[lmdb_pkg::REQ_REL_BIT];

   // Control state.
   logic [lmdb_pkg::LENGTH_W-1:0] max_length_ff;
   logic [CW-1:0]                 fill0_ff, fill0_in;
   logic [CW-1:0]                 fill1_ff, fill1_in;
   logic                          held_valid_ff, held_valid_in;
   logic                          held_index_ff, held_index_in;
   logic [lmdb_pkg::ID_W-1:0]     newest_id_ff, newest_id_in;
   logic                          open_flag_ff, open_flag_in;
   logic                          open_target_ff, open_target_in;
   logic [lmdb_pkg::ID_W-1:0]     open_id_ff, open_id_in;
   logic [CW-1:0]                 open_length_ff, open_length_in;
   logic [CW-1:0]                 write_pointer_ff, write_pointer_in;

   // Stage one: result fields waiting for the store read.
   logic                          s1_valid_ff;
   lmdb_pkg::status_type          s1_status_ff, s1_status_in;
   logic                          s1_index_ff, s1_index_in;
   logic [lmdb_pkg::LENGTH_W-1:0] s1_length_ff, s1_length_in;
   logic                          s1_use_data_ff, s1_use_data_in;

   // Response register.
   logic                              rsp_valid_ff;
   logic [lmdb_pkg::RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // Store ports.
   logic                          wr_en, rd_en;
   logic [AW:0]                   wr_addr, rd_addr;
   logic [lmdb_pkg::BYTE_W-1:0]   rd_data;

   // Handshakes.
   logic req_fire, s1_move, rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Widened operands for the length and offset checks.
   logic [CMP_W-1:0]              plen_x, maxlen_x, offset_x, held_fill_x;
   logic [CW-1:0]                 held_fill, wp_next;
   logic [lmdb_pkg::ID_W-1:0]     id_diff;
   logic                          start_target;

   assign plen_x      = CMP_W'(payload_length);
   assign maxlen_x    = CMP_W'(max_length_ff);
   assign offset_x    = CMP_W'(read_offset);
   assign held_fill   = held_index_ff ? fill1_ff : fill0_ff;
   assign held_fill_x = CMP_W'(held_fill);
   assign id_diff     = message_id - newest_id_ff;
   assign wp_next     = write_pointer_ff + CW'(1);
   assign start_target = held_valid_ff ? !held_index_ff : 1'b0;

   assign wr_addr = {open_target_ff, write_pointer_ff[AW-1:0]};
   assign rd_addr = {held_index_ff, offset_x[AW-1:0]};

   // Per-item decision and next state.
   always_comb begin
      fill0_in         = fill0_ff;
      fill1_in         = fill1_ff;
      held_valid_in    = held_valid_ff;
      held_index_in    = held_index_ff;
      newest_id_in     = newest_id_ff;
      open_flag_in     = open_flag_ff;
      open_target_in   = open_target_ff;
      open_id_in       = open_id_ff;
      open_length_in   = open_length_ff;
      write_pointer_in = write_pointer_ff;
      s1_status_in     = lmdb_pkg::ST_IGNORED;
      s1_index_in      = 1'b0;
      s1_length_in     = '0;
      s1_use_data_in   = 1'b0;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      if (req_fire) begin
         case (opcode)
            lmdb_pkg::OP_START: begin
               // Any open message is abandoned first.
               open_flag_in     = 1'b0;
               write_pointer_in = '0;
               if (!(plen_x > maxlen_x) && !(plen_x > BUF_LIMIT) &&
                   (id_diff != '0) && !id_diff[lmdb_pkg::ID_W-1]) begin
                  open_target_in = start_target;
                  open_id_in     = message_id;
                  open_length_in = CW'(payload_length);
                  if (start_target) fill1_in = '0;
                  else              fill0_in = '0;
                  if (payload_length == '0) begin
                     // Empty message commits at once.
                     newest_id_in = message_id;
                     if (!held_valid_ff) begin
                        fill0_in = '0;
                        fill1_in = '0;
                     end
                  end else begin
                     open_flag_in = 1'b1;
                  end
                  s1_status_in = lmdb_pkg::ST_OK;
               end
            end
            lmdb_pkg::OP_BYTE: begin
               if (open_flag_ff && (write_pointer_ff < open_length_ff)) begin
                  wr_en            = 1'b1;
                  write_pointer_in = wp_next;
                  if (wp_next == open_length_ff) begin
                     // Last byte: record the size and make the id newest.
                     if (open_target_ff) fill1_in = open_length_ff;
                     else                fill0_in = open_length_ff;
                     if (!held_valid_ff) begin
                        if (open_target_ff) fill0_in = '0;
                        else                fill1_in = '0;
                     end
                     newest_id_in     = open_id_ff;
                     open_flag_in     = 1'b0;
                     write_pointer_in = '0;
                  end
                  s1_status_in = lmdb_pkg::ST_OK;
               end
            end
            lmdb_pkg::OP_ACQUIRE: begin
               if (open_flag_ff) begin
                  s1_status_in = lmdb_pkg::ST_BUSY;
               end else if (held_valid_ff) begin
                  s1_status_in = lmdb_pkg::ST_HELD;
               end else if ((fill0_ff != '0) || (fill1_ff != '0)) begin
                  held_valid_in = 1'b1;
                  held_index_in = (fill0_ff == '0);
                  s1_index_in   = (fill0_ff == '0);
                  s1_length_in  = (fill0_ff != '0) ? lmdb_pkg::LENGTH_W'(fill0_ff)
                                                   : lmdb_pkg::LENGTH_W'(fill1_ff);
                  s1_status_in  = lmdb_pkg::ST_OK;
               end else begin
                  s1_status_in = lmdb_pkg::ST_NO_DATA;
               end
            end
            lmdb_pkg::OP_READ: begin
               if (!held_valid_ff) begin
                  s1_status_in = lmdb_pkg::ST_NOT_HELD;
               end else if ((offset_x >= held_fill_x) || (offset_x >= BUF_LIMIT)) begin
                  s1_status_in = lmdb_pkg::ST_RANGE;
               end else begin
                  rd_en          = 1'b1;
                  s1_use_data_in = 1'b1;
                  s1_status_in   = lmdb_pkg::ST_OK;
               end
            end
            lmdb_pkg::OP_RELEASE: begin
               if (open_flag_ff) begin
                  s1_status_in = lmdb_pkg::ST_BUSY;
               end else if (!held_valid_ff) begin
                  s1_status_in = lmdb_pkg::ST_NOT_HELD;
               end else if (release_buffer != held_index_ff) begin
                  s1_status_in = lmdb_pkg::ST_WRONG;
               end else begin
                  if (held_index_ff) fill1_in = '0;
                  else               fill0_in = '0;
                  held_valid_in = 1'b0;
                  s1_status_in  = lmdb_pkg::ST_OK;
               end
            end
            default: begin
               s1_status_in = lmdb_pkg::ST_IGNORED;
            end
         endcase
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff    <= lmdb_pkg::MAX_LENGTH_RESET;
         fill0_ff         <= '0;
         fill1_ff         <= '0;
         held_valid_ff    <= 1'b0;
         held_index_ff    <= 1'b0;
         newest_id_ff     <= '0;
         open_flag_ff     <= 1'b0;
         open_target_ff   <= 1'b0;
         open_id_ff       <= '0;
         open_length_ff   <= '0;
         write_pointer_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_length_ff <= csr_data;
         end
         fill0_ff         <= fill0_in;
         fill1_ff         <= fill1_in;
         held_valid_ff    <= held_valid_in;
         held_index_ff    <= held_index_in;
         newest_id_ff     <= newest_id_in;
         open_flag_ff     <= open_flag_in;
         open_target_ff   <= open_target_in;
         open_id_ff       <= open_id_in;
         open_length_ff   <= open_length_in;
         write_pointer_ff <= write_pointer_in;
      end
   end

   // Stage one valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Stage one payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_status_ff   <= s1_status_in;
         s1_index_ff    <= s1_index_in;
         s1_length_ff   <= s1_length_in;
         s1_use_data_ff <= s1_use_data_in;
      end
   end

   // Response beat assembly; the store byte joins here.
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[lmdb_pkg::RSP_STAT_LSB +: lmdb_pkg::STATUS_W] = s1_status_ff;
      rsp_data_in[lmdb_pkg::RSP_IDX_BIT] = s1_index_ff;
      rsp_data_in[lmdb_pkg::RSP_LEN_LSB +: lmdb_pkg::LENGTH_W] = s1_length_ff;
      rsp_data_in[lmdb_pkg::RSP_DATA_LSB +: lmdb_pkg::BYTE_W] =
         s1_use_data_ff ? rd_data : '0;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Byte store: buffer select in the top address bit.
   lmdb_ram #(
      .WIDTH (lmdb_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

FILE: rtl/lmdb_checker.sv
// ----------------------------------------------------------------------------
// lmdb_checker: port-level checks for the latest-message double buffer
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
module lmdb_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lmdb_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic [lmdb_pkg::STATUS_W-1:0] rsp_status;
   logic                          rsp_index;
   logic [lmdb_pkg::LENGTH_W-1:0] rsp_length;
   logic [lmdb_pkg::BYTE_W-1:0]   rsp_byte;

   assign rsp_status = rsp_tdata[lmdb_pkg::RSP_STAT_LSB +: lmdb_pkg::STATUS_W];
   assign rsp_index  = rsp_tdata[lmdb_pkg::RSP_IDX_BIT];
   assign rsp_length = rsp_tdata[lmdb_pkg::RSP_LEN_LSB +: lmdb_pkg::LENGTH_W];
   assign rsp_byte   = rsp_tdata[lmdb_pkg::RSP_DATA_LSB +: lmdb_pkg::BYTE_W];

   // A stalled response beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // No response beat right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // A granted buffer or length only comes with an ok status and no read byte.
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_index || (rsp_length != '0)) |->
         rsp_status == lmdb_pkg::ST_OK && rsp_byte == '0)
      else $error("grant fields set on a refused beat");

   // A read byte only comes with an ok status and no grant.
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_byte != '0) |->
         rsp_status == lmdb_pkg::ST_OK && rsp_length == '0 && !rsp_index)
      else $error("read byte set on a refused or grant beat");

   // Pad bits are always zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[lmdb_pkg::RSP_TDATA_W-1:lmdb_pkg::RSP_USED_W] == '0)
      else $error("response pad bits not zero");

endmodule

bind latest_message_double_buffer lmdb_checker u_lmdb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
